/* hdl/etsm_pkg.sv */
// shared types and constants for the engine test stand safety mode controller
package etsm_pkg;

  typedef enum logic [2:0] {
    MODE_INIT   = 3'd0,
    MODE_READY  = 3'd1,
    MODE_SEQ    = 3'd2,
    MODE_POST   = 3'd3,
    MODE_MANUAL = 3'd4,
    MODE_ABORT  = 3'd5
  } mode_t;

  localparam logic [2:0] KIND_TICK    = 3'd0;
  localparam logic [2:0] KIND_SWITCH  = 3'd1;
  localparam logic [2:0] KIND_RAISE   = 3'd2;
  localparam logic [2:0] KIND_ABORT   = 3'd3;
  localparam logic [2:0] KIND_REQUEST = 3'd4;

  localparam logic [1:0] SEQ_CMD_NONE   = 2'd0;
  localparam logic [1:0] SEQ_CMD_READY  = 2'd1;
  localparam logic [1:0] SEQ_CMD_FAILED = 2'd2;
  localparam logic [1:0] SEQ_CMD_UNINIT = 2'd3;

  localparam logic [2:0] SEQ_MODE_FAILED = 3'd2;
  localparam logic [2:0] SEQ_MODE_FIRE   = 3'd3;

  // register indexes on the configuration port
  localparam logic [2:0] REG_COLD_FLOW    = 3'd0;
  localparam logic [2:0] REG_MIN_PRESSURE = 3'd1;
  localparam logic [2:0] REG_HB_LOST      = 3'd2;
  localparam logic [2:0] REG_LINK_FAIL    = 3'd3;
  localparam logic [2:0] REG_SERVO_BIT    = 3'd4;
  localparam logic [2:0] REG_REMOTE_BIT   = 3'd5;
  localparam logic [2:0] REG_ADC_BIT      = 3'd6;

  localparam logic [14:0] MIN_PRESSURE_RESET = 15'd300;
  localparam logic [7:0]  HB_LOST_RESET      = 8'd1;
  localparam logic [7:0]  LINK_FAIL_RESET    = 8'd2;
  localparam logic [2:0]  SERVO_BIT_RESET    = 3'd2;
  localparam logic [2:0]  REMOTE_BIT_RESET   = 3'd1;
  localparam logic [2:0]  ADC_BIT_RESET      = 3'd3;

  // switch snapshot bit positions
  localparam int SV_CHANGED  = 9;
  localparam int SV_VALVE    = 7;
  localparam int SV_PYRO     = 6;
  localparam int SV_OVERRIDE = 5;

  typedef struct packed {
    logic        cold_flow_mode;
    logic [14:0] min_mainline_pressure;
    logic [7:0]  heartbeat_lost_code;
    logic [7:0]  link_restart_fail_code;
    logic [2:0]  servo_board_bit;
    logic [2:0]  remote_board_bit;
    logic [2:0]  adc_board_bit;
  } cfg_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [15:0]        switches;
    logic               interlock_released;
    logic               igniter_continuity;
    logic               valves_all_closed;
    logic signed [15:0] mainline_pressure;
    logic               heartbeats_started;
    logic [7:0]         heartbeat_status;
    logic [2:0]         sequencer_mode;
    logic [7:0]         error_in;
    logic [2:0]         requested_mode;
  } item_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] fault_code;
    logic       make_safe;
    logic [1:0] sequencer_command;
    logic       sequencer_step;
    logic       manual_update;
    logic       manual_safe;
    logic       abort_notify;
    logic       error_report;
    logic       invalid_request;
    logic [9:0] switch_view;
  } res_t;

endpackage

/* hdl/etsm_cfg.sv */
// configuration registers behind the apb-style port
module etsm_cfg import etsm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cold_flow_mode         <= 1'b0;
      cfg.min_mainline_pressure  <= MIN_PRESSURE_RESET;
      cfg.heartbeat_lost_code    <= HB_LOST_RESET;
      cfg.link_restart_fail_code <= LINK_FAIL_RESET;
      cfg.servo_board_bit        <= SERVO_BIT_RESET;
      cfg.remote_board_bit       <= REMOTE_BIT_RESET;
      cfg.adc_board_bit          <= ADC_BIT_RESET;
    end else if (wr) begin
      case (idx)
        REG_COLD_FLOW:    cfg.cold_flow_mode         <= pwdata[0];
        REG_MIN_PRESSURE: cfg.min_mainline_pressure  <= pwdata[14:0];
        REG_HB_LOST:      cfg.heartbeat_lost_code    <= pwdata[7:0];
        REG_LINK_FAIL:    cfg.link_restart_fail_code <= pwdata[7:0];
        REG_SERVO_BIT:    cfg.servo_board_bit        <= pwdata[2:0];
        REG_REMOTE_BIT:   cfg.remote_board_bit       <= pwdata[2:0];
        REG_ADC_BIT:      cfg.adc_board_bit          <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_COLD_FLOW:    prdata = {31'd0, cfg.cold_flow_mode};
      REG_MIN_PRESSURE: prdata = {17'd0, cfg.min_mainline_pressure};
      REG_HB_LOST:      prdata = {24'd0, cfg.heartbeat_lost_code};
      REG_LINK_FAIL:    prdata = {24'd0, cfg.link_restart_fail_code};
      REG_SERVO_BIT:    prdata = {29'd0, cfg.servo_board_bit};
      REG_REMOTE_BIT:   prdata = {29'd0, cfg.remote_board_bit};
      REG_ADC_BIT:      prdata = {29'd0, cfg.adc_board_bit};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

/* hdl/etsm_core.sv */
// mode state registers and the per-word mode transition logic
module etsm_core import etsm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  step,
  input  item_t item,
  input  cfg_t  cfg,
  output res_t  res
);

  mode_t       mode_reg, mode_next;
  logic [7:0]  error_reg, error_next;
  logic [15:0] last_switch_word, last_switch_word_next;
  logic [9:0]  sw_latch, sw_latch_next;

  logic  arm_pair, override_on, changed, checks_ok, firing, hb_lost;
  logic  go;
  mode_t target;
  logic  view_held;
  logic [9:0] view_hold;

  assign arm_pair    = sw_latch[SV_VALVE] && sw_latch[SV_PYRO];
  assign override_on = sw_latch[SV_OVERRIDE];
  assign changed     = sw_latch[SV_CHANGED];
  assign firing      = (item.sequencer_mode == SEQ_MODE_FIRE);

  assign checks_ok = arm_pair && !override_on && item.interlock_released &&
                     (cfg.cold_flow_mode || item.igniter_continuity) &&
                     item.valves_all_closed &&
                     (item.mainline_pressure >= $signed({1'b0, cfg.min_mainline_pressure}));

  assign hb_lost = !item.heartbeat_status[cfg.servo_board_bit] ||
                   (!firing && (!item.heartbeat_status[cfg.remote_board_bit] ||
                                !item.heartbeat_status[cfg.adc_board_bit]));

  always_comb begin
    res                   = '0;
    go                    = 1'b0;
    target                = mode_reg;
    error_next            = error_reg;
    last_switch_word_next = last_switch_word;
    sw_latch_next         = sw_latch;
    view_held             = 1'b0;
    view_hold             = sw_latch;

    case (item.kind)
      KIND_TICK: begin
        case (mode_reg)
          MODE_INIT: begin
            if (item.heartbeats_started) begin
              go = 1'b1; target = MODE_READY;
            end
          end
          MODE_READY: begin
            if (override_on) begin
              go = 1'b1; target = MODE_MANUAL;
            end else if (checks_ok) begin
              go = 1'b1; target = MODE_SEQ;
            end
          end
          MODE_SEQ: begin
            if (!arm_pair || override_on || !item.interlock_released) begin
              go     = 1'b1;
              target = (item.sequencer_mode <= SEQ_MODE_FAILED) ? MODE_READY : MODE_ABORT;
            end else begin
              res.sequencer_step = 1'b1;
            end
          end
          MODE_POST: begin
            if (!arm_pair && !item.interlock_released) begin
              go = 1'b1; target = MODE_READY;
            end
          end
          MODE_MANUAL: begin
            if (!override_on) begin
              go = 1'b1; target = MODE_READY;
            end else if (changed) begin
              // hand the snapshot out once, then drop the changed mark
              res.manual_update = 1'b1;
              view_held = 1'b1;
              sw_latch_next[SV_CHANGED] = 1'b0;
            end
          end
          default: begin
            if (!sw_latch[SV_PYRO] && !sw_latch[SV_VALVE] && !override_on &&
                !item.interlock_released && changed) begin
              go = 1'b1; target = MODE_READY;
            end
          end
        endcase
      end
      KIND_SWITCH: begin
        if (item.switches != last_switch_word)
          sw_latch_next = {1'b1, item.switches[15:12], item.switches[7:3]};
        last_switch_word_next = item.switches;
      end
      KIND_RAISE: begin
        res.error_report = 1'b1;
        // heartbeat rule wins when both codes are equal
        if (item.error_in == cfg.heartbeat_lost_code) begin
          if (hb_lost) begin
            error_next = cfg.heartbeat_lost_code;
            go = 1'b1; target = MODE_ABORT;
          end
        end else if (item.error_in == cfg.link_restart_fail_code) begin
          if (!firing) begin
            error_next = cfg.link_restart_fail_code;
            go = 1'b1; target = MODE_ABORT;
          end
        end else begin
          go = 1'b1; target = MODE_ABORT;
        end
      end
      KIND_ABORT: begin
        error_next = item.error_in;
        go = 1'b1; target = MODE_ABORT;
      end
      KIND_REQUEST: begin
        if (item.requested_mode > 3'(MODE_ABORT)) begin
          res.invalid_request = 1'b1;
        end else begin
          go = 1'b1; target = mode_t'(item.requested_mode);
        end
      end
      default: ;
    endcase

    mode_next = mode_reg;
    if (go && (target != mode_reg)) begin
      // exit actions of the old mode
      case (mode_reg)
        MODE_INIT: res.make_safe = 1'b1;
        MODE_SEQ: begin
          res.make_safe = 1'b1;
          res.sequencer_command = SEQ_CMD_UNINIT;
        end
        MODE_MANUAL: res.manual_safe = 1'b1;
        MODE_ABORT:  error_next = 8'd0;
        default: ;
      endcase
      // entry actions of the new mode
      case (target)
        MODE_INIT: res.make_safe = 1'b1;
        MODE_SEQ:  res.sequencer_command = checks_ok ? SEQ_CMD_READY : SEQ_CMD_FAILED;
        MODE_ABORT: begin
          res.make_safe = 1'b1;
          res.abort_notify = 1'b1;
          sw_latch_next[SV_CHANGED] = 1'b0;
        end
        default: ;
      endcase
      mode_next = target;
    end

    res.mode        = mode_next;
    res.fault_code  = error_next;
    res.switch_view = view_held ? view_hold : sw_latch_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg         <= MODE_INIT;
      error_reg        <= 8'd0;
      last_switch_word <= 16'd0;
      sw_latch         <= 10'd0;
    end else if (step) begin
      mode_reg         <= mode_next;
      error_reg        <= error_next;
      last_switch_word <= last_switch_word_next;
      sw_latch         <= sw_latch_next;
    end
  end

endmodule

/* hdl/engine_test_safety_mode_fsm_top.sv */
// engine test stand safety mode controller: input register, mode logic, result register
// an accepted word waits in the input register, its result word in the result register
// throughput: one word per cycle unless stalled, set by the combinational mode update
// between the registers; both stall together while out_valid is high and out_ready low
// reset (synchronous, rst high): mode init, error code, switch word and snapshot zero,
// configuration registers to their defaults; no actions are signaled at reset
module engine_test_safety_mode_fsm_top import etsm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  kind,
  input  logic [15:0] switches,
  input  logic        interlock_released,
  input  logic        igniter_continuity,
  input  logic        valves_all_closed,
  input  logic signed [15:0] mainline_pressure,
  input  logic        heartbeats_started,
  input  logic [7:0]  heartbeat_status,
  input  logic [2:0]  sequencer_mode,
  input  logic [7:0]  error_in,
  input  logic [2:0]  requested_mode,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  mode,
  output logic [7:0]  fault_code,
  output logic        make_safe,
  output logic [1:0]  sequencer_command,
  output logic        sequencer_step,
  output logic        manual_update,
  output logic        manual_safe,
  output logic        abort_notify,
  output logic        error_report,
  output logic        invalid_request,
  output logic [9:0]  switch_view
);

  cfg_t  cfg;
  item_t item_q;
  logic  item_valid;
  logic  advance;
  res_t  res;
  res_t  res_q;

  etsm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  etsm_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (item_q),
    .cfg  (cfg),
    .res  (res)
  );

  // held word moves on when the result register is empty or being drained
  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_ready)
        item_valid <= in_valid;
      if (advance)
        out_valid <= 1'b1;
      else if (out_ready)
        out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_q.kind               <= kind;
      item_q.switches           <= switches;
      item_q.interlock_released <= interlock_released;
      item_q.igniter_continuity <= igniter_continuity;
      item_q.valves_all_closed  <= valves_all_closed;
      item_q.mainline_pressure  <= mainline_pressure;
      item_q.heartbeats_started <= heartbeats_started;
      item_q.heartbeat_status   <= heartbeat_status;
      item_q.sequencer_mode     <= sequencer_mode;
      item_q.error_in           <= error_in;
      item_q.requested_mode     <= requested_mode;
    end
    if (advance)
      res_q <= res;
  end

  assign mode              = res_q.mode;
  assign fault_code        = res_q.fault_code;
  assign make_safe         = res_q.make_safe;
  assign sequencer_command = res_q.sequencer_command;
  assign sequencer_step    = res_q.sequencer_step;
  assign manual_update     = res_q.manual_update;
  assign manual_safe       = res_q.manual_safe;
  assign abort_notify      = res_q.abort_notify;
  assign error_report      = res_q.error_report;
  assign invalid_request   = res_q.invalid_request;
  assign switch_view       = res_q.switch_view;

endmodule
